/* rtl/gfba_pkg.sv */
// ----------------------------------------------------------------------------
// gfba_pkg: shared constants for the grouped free-block allocator
// Sizes, field widths, request kinds and status codes.
// ----------------------------------------------------------------------------
package gfba_pkg;

  // sizing
  localparam int STACK_ENTRIES = 32;
  localparam int BLOCK_COUNT   = 1024;
  localparam int GROUP_WORDS   = STACK_ENTRIES + 1;
  localparam int STORE_DEPTH   = BLOCK_COUNT * GROUP_WORDS;

  // field widths
  localparam int BLK_W    = 10;
  localparam int FREE_W   = 11;
  localparam int STATUS_W = 2;

  // derived widths
  localparam int STK_AW   = $clog2(STACK_ENTRIES);
  localparam int CNT_W    = $clog2(STACK_ENTRIES + 1);
  localparam int STEP_W   = $clog2(STACK_ENTRIES + 2);
  localparam int STORE_AW = $clog2(STORE_DEPTH);

  // stream packing
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 1 + STATUS_W;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

/* rtl/gfba_ram.sv */
// ----------------------------------------------------------------------------
// gfba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/grouped_free_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_top: grouped free-block list allocator
// Free stack and group store live in RAM; a sequencer pops, pushes, spills
// and refills them one word per cycle.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Contents
// --------  ---  ------------------------------------------------------------
// s_axis    in   tuser: req_type; tdata: block_number (padded to 16 bits)
// m_axis    out  tuser: grant_valid, status; tdata: granted_block, free_total
//
// A free that finds the stack full spills it to the group store, and an alloc
//   that empties the stack refills it from the group store;
//   spill and refill move one group word per cycle through the RAM ports.
// Reset clears the sequencer, stack count, free counter and output valid;
//   neither RAM is cleared (stack entries are written before they are read,
//   the group store is read only after a spill wrote it).
// s_axis_tready is high while the sequencer is idle. A finished result sits
//   in the output register; the sequencer stalls only if a second result is
//   ready before the first was taken.
//
module grouped_free_block_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gfba_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [9:0] block_number
  input  logic                              s_axis_tuser,  // [0] req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gfba_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [9:0] granted_block,
                                                           // [20:10] free_total
  output logic [gfba_pkg::OUT_USER_W-1:0]   m_axis_tuser   // [0] grant_valid,
                                                           // [2:1] status
);

  import gfba_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;  // decide, issue stack access
  localparam logic [2:0] S_POPW   = 3'd2;  // popped entry returns
  localparam logic [2:0] S_REFILL = 3'd3;  // group store -> stack
  localparam logic [2:0] S_SPILL  = 3'd4;  // stack -> group store
  localparam logic [2:0] S_FINISH = 3'd5;  // hand result to output register

  logic [2:0]          state_q, state_d;
  logic                req_q;
  logic [BLK_W-1:0]    blk_q;
  logic [STORE_AW-1:0] base_q, base_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;      // stack count, spilled as group word 0
  logic [CNT_W-1:0]    n_q, n_d;          // clamped count of group being refilled
  logic [FREE_W-1:0]   ctr_q, ctr_d;      // free counter
  logic [STEP_W-1:0]   step_q, step_d;
  logic [BLK_W-1:0]    res_blk_q, res_blk_d;
  logic                res_gv_q, res_gv_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;

  logic                out_valid_q;
  logic [BLK_W-1:0]    out_blk_q;
  logic                out_gv_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [FREE_W-1:0]   out_free_q;

  logic                s_hs;
  logic                out_load;

  // RAM ports
  logic                stk_we, stk_re;
  logic [STK_AW-1:0]   stk_waddr, stk_raddr;
  logic [BLK_W-1:0]    stk_wdata, stk_rdata;
  logic                grp_we, grp_re;
  logic [STORE_AW-1:0] grp_waddr, grp_raddr;
  logic [BLK_W-1:0]    grp_wdata, grp_rdata;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_FINISH) && (!out_valid_q || m_axis_tready);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    ctr_d     = ctr_q;
    step_d    = step_q;
    res_blk_d = res_blk_q;
    res_gv_d  = res_gv_q;
    res_st_d  = res_st_q;

    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = blk_q;
    stk_re    = 1'b0;
    stk_raddr = '0;
    grp_we    = 1'b0;
    grp_waddr = base_q + STORE_AW'(step_q);
    grp_wdata = stk_rdata;
    grp_re    = 1'b0;
    grp_raddr = base_q + STORE_AW'(step_q);

    unique case (state_q)
      S_IDLE: begin
        if (s_hs) begin
          // group base of the freed block, used if the push spills
          base_d  = STORE_AW'(s_axis_tdata[BLK_W-1:0]) * STORE_AW'(GROUP_WORDS);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_blk_d = '0;
        res_gv_d  = 1'b0;
        res_st_d  = ST_OK;
        step_d    = '0;
        state_d   = S_FINISH;
        if (req_q == REQ_ALLOC) begin
          if (ctr_q == '0 || cnt_q == '0 || 32'(cnt_q) > STACK_ENTRIES) begin
            res_st_d = ST_NO_FREE;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = STK_AW'(cnt_q - CNT_W'(1));
            state_d   = S_POPW;
          end
        end else begin
          priority if (32'(blk_q) >= BLOCK_COUNT) begin
            // out-of-range block: ignored
          end else if (32'(ctr_q) >= BLOCK_COUNT) begin
            ctr_d    = FREE_W'(BLOCK_COUNT);
            res_st_d = ST_OVERFLOW;
          end else begin
            ctr_d = ctr_q + FREE_W'(1);
            if (32'(cnt_q) < STACK_ENTRIES) begin
              stk_we    = 1'b1;
              stk_waddr = STK_AW'(cnt_q);
              cnt_d     = cnt_q + CNT_W'(1);
            end else begin
              state_d = S_SPILL;
            end
          end
        end
      end

      S_POPW: begin
        res_blk_d = stk_rdata;
        res_gv_d  = 1'b1;
        cnt_d     = cnt_q - CNT_W'(1);
        ctr_d     = ctr_q - FREE_W'(1);
        state_d   = S_FINISH;
        // popped the group header with blocks still free elsewhere: refill
        if (cnt_q == CNT_W'(1) && ctr_q != FREE_W'(1) &&
            32'(stk_rdata) < BLOCK_COUNT) begin
          base_d  = STORE_AW'(stk_rdata) * STORE_AW'(GROUP_WORDS);
          step_d  = '0;
          state_d = S_REFILL;
        end
      end

      S_REFILL: begin
        // read word s at step s, its data lands at step s+1
        if (32'(step_q) <= STACK_ENTRIES) begin
          grp_re = 1'b1;
        end
        if (step_q == STEP_W'(1)) begin
          if (32'(grp_rdata) > STACK_ENTRIES) begin
            n_d = CNT_W'(STACK_ENTRIES);
          end else begin
            n_d = CNT_W'(grp_rdata);
          end
          cnt_d = n_d;
        end else if (step_q >= STEP_W'(2) && 32'(step_q) <= 32'(n_q) + 1) begin
          stk_we    = 1'b1;
          stk_waddr = STK_AW'(step_q - STEP_W'(2));
          stk_wdata = grp_rdata;
        end
        step_d = step_q + STEP_W'(1);
        if (32'(step_q) == STACK_ENTRIES + 1) begin
          state_d = S_FINISH;
        end
      end

      S_SPILL: begin
        // word 0 is the full count, word s (s >= 1) is stack entry s
        grp_we = 1'b1;
        if (step_q == '0) begin
          grp_wdata = BLK_W'(STACK_ENTRIES);
        end
        if (32'(step_q) < STACK_ENTRIES) begin
          stk_re    = 1'b1;
          stk_raddr = STK_AW'(step_q);
        end
        step_d = step_q + STEP_W'(1);
        if (32'(step_q) == STACK_ENTRIES) begin
          // stack restarts holding only the freed block
          stk_we    = 1'b1;
          stk_waddr = '0;
          cnt_d     = CNT_W'(1);
          state_d   = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ctr_q   <= ctr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      req_q <= s_axis_tuser;
      blk_q <= s_axis_tdata[BLK_W-1:0];
    end
    base_q    <= base_d;
    n_q       <= n_d;
    step_q    <= step_d;
    res_blk_q <= res_blk_d;
    res_gv_q  <= res_gv_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_blk_q  <= res_blk_q;
      out_gv_q   <= res_gv_q;
      out_st_q   <= res_st_q;
      out_free_q <= ctr_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - BLK_W - FREE_W){1'b0}}, out_free_q, out_blk_q};
  assign m_axis_tuser  = {out_st_q, out_gv_q};

  // --------------------------------------------------------------------------
  // Memories. Stack entry k lives at address k-1; the count is cnt_q.
  // Requests are serialized, so no access of one request overlaps another.
  // --------------------------------------------------------------------------
  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (STACK_ENTRIES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (STORE_DEPTH)
  ) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (grp_we),
    .waddr_i (grp_waddr),
    .wdata_i (grp_wdata),
    .re_i    (grp_re),
    .raddr_i (grp_raddr),
    .rdata_o (grp_rdata)
  );

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= STACK_ENTRIES)
    else $error("stack count above capacity");

  a_ctr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ctr_q) <= BLOCK_COUNT)
    else $error("free counter above block count");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> state_q == S_EXEC)
    else $error("accepted request not executed");

  a_spill_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPILL && 32'(step_q) == STACK_ENTRIES) |=> cnt_q == CNT_W'(1))
    else $error("stack did not restart after spill");

  a_ctr_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_q != $past(ctr_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_POPW))
    else $error("free counter changed outside a request");
`endif

endmodule
